/* hdl/apcc_pkg.sv */
// Package for the alarm / pomodoro clock controller.
// Holds register indexes, chirp codes, divider constants and the display word type.
// No dependencies.
`default_nettype none
package apcc_pkg;

  localparam int DEF_MAX_PHASE_MINUTES = 99;
  localparam int DEF_TIMESTAMP_WIDTH   = 32;

  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLINK      = 2'd2;

  localparam logic [CFG_W-1:0] LONG_PRESS_RST = 16'd1000;
  localparam logic [CFG_W-1:0] DEBOUNCE_RST   = 16'd200;
  localparam logic [CFG_W-1:0] BLINK_RST      = 16'd500;

  localparam int CHIRP_W = 3;
  localparam logic [CHIRP_W-1:0] CHIRP_NONE   = 3'd0;
  localparam logic [CHIRP_W-1:0] CHIRP_100    = 3'd1;
  localparam logic [CHIRP_W-1:0] CHIRP_200    = 3'd2;
  localparam logic [CHIRP_W-1:0] CHIRP_2X150  = 3'd3;
  localparam logic [CHIRP_W-1:0] CHIRP_2X100  = 3'd4;
  localparam logic [CHIRP_W-1:0] CHIRP_3X150  = 3'd5;

  localparam int HOUR_W    = 5;
  localparam int MINUTE_W  = 6;
  localparam int PHASE_M_W = 7;
  localparam int PHASE_L_W = 23;
  localparam int VALUE_W   = 14;
  localparam int HI_W      = 8;
  localparam int SECS_W    = 14;

  localparam logic [HOUR_W-1:0]   HOURS_PER_DAY   = 5'd24;
  localparam logic [MINUTE_W-1:0] MINUTES_PER_HR  = 6'd60;
  localparam logic [MINUTE_W-1:0] MINUTE_NONE     = 6'd63;
  localparam logic [15:0]         MS_PER_MINUTE   = 16'd60000;

  // floor(x/1000) = (x * REC_1000) >> SH_1000 for x < 2^23
  localparam logic [23:0] REC_1000 = 24'd8589935;
  localparam int          SH_1000  = 33;
  // floor(x/60) = (x * REC_60) >> SH_60 for x < 2^14
  localparam logic [14:0] REC_60   = 15'd17477;
  localparam int          SH_60    = 20;

  typedef struct packed {
    logic [HI_W-1:0]      hi;
    logic [MINUTE_W-1:0]  lo;
    logic [PHASE_L_W-1:0] num;
    logic                 use_div;
    logic                 colon;
    logic                 blank;
    logic                 buzzer;
    logic [CHIRP_W-1:0]   chirp;
  } disp_t;

endpackage
`default_nettype wire

/* hdl/alarm_pomodoro_clock_controller.sv */
// Top level of the alarm / pomodoro clock controller: tick handling and display pipeline.
// Depends on apcc_pkg.
//
// One tick word is accepted per clock cycle when the output side does not stall. The
// rate is set by the controller state update, done combinationally between the input
// register and the first display stage; the later stages turn the remaining pomodoro
// time into minutes and seconds by reciprocal multiplies and form the four digit value.
// Each stage holds its word while the next one is full and cannot move on, so a stall
// on the output side holds every full stage behind it.
`default_nettype none
module alarm_pomodoro_clock_controller
  import apcc_pkg::*;
#(
  parameter int MAX_PHASE_MINUTES = DEF_MAX_PHASE_MINUTES,
  parameter int TIMESTAMP_WIDTH   = DEF_TIMESTAMP_WIDTH
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [CFG_W-1:0]           cfg_data,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [TIMESTAMP_WIDTH-1:0] in_now_ms,
  input  wire logic [HOUR_W-1:0]          in_rtc_hour,
  input  wire logic [MINUTE_W-1:0]        in_rtc_minute,
  input  wire logic                       in_hour_button,
  input  wire logic                       in_minute_button,
  input  wire logic                       in_mode_button,
  input  wire logic                       in_pomo_button,
  input  wire logic                       in_reset_button,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [VALUE_W-1:0]              out_display_value,
  output logic                            out_colon_on,
  output logic                            out_display_blank,
  output logic                            out_buzzer_on,
  output logic [CHIRP_W-1:0]              out_chirp_code
);

  localparam int TW = TIMESTAMP_WIDTH;
  localparam int CW = (TW > PHASE_L_W) ? TW : PHASE_L_W;
  localparam logic [PHASE_M_W:0] MAX_M = (PHASE_M_W+1)'(MAX_PHASE_MINUTES);

  // configuration
  logic [CFG_W-1:0] long_press_r, debounce_r, blink_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      long_press_r <= LONG_PRESS_RST;
      debounce_r   <= DEBOUNCE_RST;
      blink_r      <= BLINK_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_LONG_PRESS: long_press_r <= cfg_data;
        CFG_DEBOUNCE:   debounce_r   <= cfg_data;
        CFG_BLINK:      blink_r      <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline handshake
  logic v0_r, v1_r, v2_r, v3_r, v4_r, vo_r;
  logic mv0, mv1, mv2, mv3, mv4;
  logic free0, free1, free2, free3, free4, free5;

  assign free5 = !vo_r || out_ready;
  assign mv4   = v4_r && free5;
  assign free4 = !v4_r || mv4;
  assign mv3   = v3_r && free4;
  assign free3 = !v3_r || mv3;
  assign mv2   = v2_r && free3;
  assign free2 = !v2_r || mv2;
  assign mv1   = v1_r && free2;
  assign free1 = !v1_r || mv1;
  assign mv0   = v0_r && free1;
  assign free0 = !v0_r || mv0;
  assign in_ready = free0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0; v1_r <= 1'b0; v2_r <= 1'b0;
      v3_r <= 1'b0; v4_r <= 1'b0; vo_r <= 1'b0;
    end else begin
      if (free0) v0_r <= in_valid;
      if (free1) v1_r <= mv0;
      if (free2) v2_r <= mv1;
      if (free3) v3_r <= mv2;
      if (free4) v4_r <= mv3;
      if (free5) vo_r <= mv4;
    end
  end

  // input register
  logic [TW-1:0]       s0_now_r;
  logic [HOUR_W-1:0]   s0_hour_r;
  logic [MINUTE_W-1:0] s0_minute_r;
  logic s0_bh_r, s0_bm_r, s0_bmode_r, s0_bpomo_r, s0_brst_r;

  always_ff @(posedge clk) begin
    if (in_valid && free0) begin
      s0_now_r    <= in_now_ms;
      s0_hour_r   <= in_rtc_hour;
      s0_minute_r <= in_rtc_minute;
      s0_bh_r     <= in_hour_button;
      s0_bm_r     <= in_minute_button;
      s0_bmode_r  <= in_mode_button;
      s0_bpomo_r  <= in_pomo_button;
      s0_brst_r   <= in_reset_button;
    end
  end

  // controller state
  logic [HOUR_W-1:0]    alarm_hour_r, alarm_hour_nxt;
  logic [MINUTE_W-1:0]  alarm_minute_r, alarm_minute_nxt;
  logic [MINUTE_W-1:0]  last_seen_minute_r, last_seen_minute_nxt;
  logic alarm_enabled_r, alarm_enabled_nxt, alarm_set_mode_r, alarm_set_mode_nxt;
  logic alarm_ringing_r, alarm_ringing_nxt, rang_r, rang_nxt;
  logic pomo_mode_r, pomo_mode_nxt, pomo_running_r, pomo_running_nxt;
  logic work_phase_r, work_phase_nxt, pomo_ringing_r, pomo_ringing_nxt;
  logic [PHASE_M_W-1:0] work_min_r, work_min_nxt, break_min_r, break_min_nxt;
  logic [TW-1:0]        phase_start_r, phase_start_nxt;
  logic [PHASE_L_W-1:0] phase_len_r, phase_len_nxt;
  logic [TW-1:0]        mode_press_r, mode_press_nxt, pomo_press_r, pomo_press_nxt;
  logic mode_held_r, mode_held_nxt, pomo_held_r, pomo_held_nxt;
  logic [TW-1:0]        hour_step_r, hour_step_nxt, min_step_r, min_step_nxt;
  logic [TW-1:0]        blink_tog_r, blink_tog_nxt;
  logic blink_vis_r, blink_vis_nxt;

  logic [TW-1:0]        mode_since, pomo_since, hstep_since, mstep_since, blink_since;
  logic [TW-1:0]        phase_el;
  logic [CW-1:0]        el_ext, len_ext, rem_ext;
  logic [PHASE_M_W-1:0] start_min;
  logic [PHASE_M_W:0]   work_inc, break_inc;
  disp_t                s1_nxt;

  assign mode_since  = s0_now_r - mode_press_r;
  assign pomo_since  = s0_now_r - pomo_press_r;
  assign hstep_since = s0_now_r - hour_step_r;
  assign mstep_since = s0_now_r - min_step_r;
  assign blink_since = s0_now_r - blink_tog_r;

  always_comb begin
    alarm_hour_nxt       = alarm_hour_r;
    alarm_minute_nxt     = alarm_minute_r;
    last_seen_minute_nxt = last_seen_minute_r;
    alarm_enabled_nxt    = alarm_enabled_r;
    alarm_set_mode_nxt   = alarm_set_mode_r;
    alarm_ringing_nxt    = alarm_ringing_r;
    rang_nxt             = rang_r;
    pomo_mode_nxt        = pomo_mode_r;
    pomo_running_nxt     = pomo_running_r;
    work_phase_nxt       = work_phase_r;
    pomo_ringing_nxt     = pomo_ringing_r;
    work_min_nxt         = work_min_r;
    break_min_nxt        = break_min_r;
    phase_start_nxt      = phase_start_r;
    phase_len_nxt        = phase_len_r;
    mode_press_nxt       = mode_press_r;
    pomo_press_nxt       = pomo_press_r;
    mode_held_nxt        = mode_held_r;
    pomo_held_nxt        = pomo_held_r;
    hour_step_nxt        = hour_step_r;
    min_step_nxt         = min_step_r;
    blink_tog_nxt        = blink_tog_r;
    blink_vis_nxt        = blink_vis_r;
    s1_nxt               = '0;
    start_min            = '0;
    work_inc             = '0;
    break_inc            = '0;
    phase_el             = '0;
    el_ext               = '0;
    len_ext              = '0;
    rem_ext              = '0;

    if (s0_brst_r) begin
      alarm_enabled_nxt  = 1'b0;
      alarm_ringing_nxt  = 1'b0;
      alarm_set_mode_nxt = 1'b0;
      pomo_running_nxt   = 1'b0;
      pomo_ringing_nxt   = 1'b0;
      pomo_mode_nxt      = 1'b0;
      work_min_nxt       = PHASE_M_W'(1);
      break_min_nxt      = PHASE_M_W'(1);
      work_phase_nxt     = 1'b1;
      s1_nxt.chirp       = CHIRP_200;
    end

    // mode button, acts on release
    if (s0_bmode_r && !mode_held_r) begin
      mode_held_nxt  = 1'b1;
      mode_press_nxt = s0_now_r;
    end else if (!s0_bmode_r && mode_held_r) begin
      if (mode_since > TW'(long_press_r)) begin
        alarm_set_mode_nxt = !alarm_set_mode_nxt;
        pomo_mode_nxt      = 1'b0;
        s1_nxt.chirp       = CHIRP_100;
      end else if (alarm_ringing_nxt) begin
        alarm_ringing_nxt = 1'b0;
        alarm_enabled_nxt = 1'b0;
      end else if (alarm_set_mode_nxt) begin
        alarm_enabled_nxt  = 1'b1;
        alarm_set_mode_nxt = 1'b0;
        s1_nxt.chirp       = CHIRP_2X150;
      end else begin
        alarm_enabled_nxt = !alarm_enabled_nxt;
        s1_nxt.chirp      = alarm_enabled_nxt ? CHIRP_200 : CHIRP_100;
      end
      mode_held_nxt = 1'b0;
    end

    // pomodoro button, acts on release
    if (s0_bpomo_r && !pomo_held_r) begin
      pomo_held_nxt  = 1'b1;
      pomo_press_nxt = s0_now_r;
    end else if (!s0_bpomo_r && pomo_held_r) begin
      if (pomo_since > TW'(long_press_r)) begin
        pomo_mode_nxt      = !pomo_mode_nxt;
        alarm_set_mode_nxt = 1'b0;
        s1_nxt.chirp       = CHIRP_100;
      end else if (pomo_ringing_nxt) begin
        pomo_ringing_nxt = 1'b0;
      end else if (pomo_mode_nxt && !pomo_running_nxt) begin
        pomo_running_nxt = 1'b1;
        phase_start_nxt  = s0_now_r;
        start_min        = work_phase_nxt ? work_min_nxt : break_min_nxt;
        phase_len_nxt    = PHASE_L_W'(start_min) * PHASE_L_W'(MS_PER_MINUTE);
        s1_nxt.chirp     = CHIRP_2X100;
      end else if (pomo_running_nxt) begin
        pomo_running_nxt = 1'b0;
        s1_nxt.chirp     = CHIRP_100;
      end
      pomo_held_nxt = 1'b0;
    end

    // adjust buttons
    if (alarm_set_mode_nxt) begin
      if (s0_bh_r && hstep_since > TW'(debounce_r)) begin
        alarm_hour_nxt = (alarm_hour_r == HOURS_PER_DAY - HOUR_W'(1)) ? '0 :
                         alarm_hour_r + HOUR_W'(1);
        hour_step_nxt  = s0_now_r;
      end
      if (s0_bm_r && mstep_since > TW'(debounce_r)) begin
        alarm_minute_nxt = (alarm_minute_r == MINUTES_PER_HR - MINUTE_W'(1)) ? '0 :
                           alarm_minute_r + MINUTE_W'(1);
        min_step_nxt     = s0_now_r;
      end
    end else if (pomo_mode_nxt && !pomo_running_nxt) begin
      if (s0_bh_r && hstep_since > TW'(debounce_r)) begin
        work_inc      = {1'b0, work_min_nxt} + (PHASE_M_W+1)'(1);
        work_min_nxt  = (work_inc > MAX_M) ? '0 : work_inc[PHASE_M_W-1:0];
        hour_step_nxt = s0_now_r;
      end
      if (s0_bm_r && mstep_since > TW'(debounce_r)) begin
        break_inc     = {1'b0, break_min_nxt} + (PHASE_M_W+1)'(1);
        break_min_nxt = (break_inc > MAX_M) ? '0 : break_inc[PHASE_M_W-1:0];
        min_step_nxt  = s0_now_r;
      end
    end

    // display
    phase_el = s0_now_r - phase_start_nxt;
    el_ext   = CW'(phase_el);
    len_ext  = CW'(phase_len_nxt);
    rem_ext  = len_ext - el_ext;
    if (alarm_set_mode_nxt) begin
      if (blink_since > TW'(blink_r)) begin
        blink_vis_nxt = !blink_vis_r;
        blink_tog_nxt = s0_now_r;
      end
      if (blink_vis_nxt) begin
        s1_nxt.hi    = HI_W'(alarm_hour_nxt);
        s1_nxt.lo    = alarm_minute_nxt;
        s1_nxt.colon = 1'b1;
      end else begin
        s1_nxt.blank = 1'b1;
      end
    end else if (pomo_mode_nxt) begin
      if (pomo_running_nxt) begin
        s1_nxt.colon = 1'b1;
        if (el_ext < len_ext) begin
          s1_nxt.use_div = 1'b1;
          s1_nxt.num     = rem_ext[PHASE_L_W-1:0];
        end
      end else begin
        s1_nxt.hi = HI_W'(work_min_nxt);
      end
    end else begin
      s1_nxt.hi    = HI_W'(s0_hour_r);
      s1_nxt.lo    = s0_minute_r;
      s1_nxt.colon = 1'b1;
    end

    // alarm match
    if (s0_minute_r != last_seen_minute_r) begin
      last_seen_minute_nxt = s0_minute_r;
      rang_nxt             = 1'b0;
    end
    if (alarm_enabled_nxt && s0_hour_r == alarm_hour_nxt &&
        s0_minute_r == alarm_minute_nxt && !rang_nxt) begin
      rang_nxt          = 1'b1;
      alarm_ringing_nxt = 1'b1;
    end

    // phase completion
    if (pomo_running_nxt && el_ext >= len_ext) begin
      pomo_running_nxt = 1'b0;
      pomo_ringing_nxt = 1'b1;
      work_phase_nxt   = !work_phase_nxt;
      s1_nxt.chirp     = CHIRP_3X150;
    end

    s1_nxt.buzzer = alarm_ringing_nxt || pomo_ringing_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alarm_hour_r       <= '0;
      alarm_minute_r     <= '0;
      last_seen_minute_r <= MINUTE_NONE;
      alarm_enabled_r    <= 1'b0;
      alarm_set_mode_r   <= 1'b0;
      alarm_ringing_r    <= 1'b0;
      rang_r             <= 1'b0;
      pomo_mode_r        <= 1'b0;
      pomo_running_r     <= 1'b0;
      work_phase_r       <= 1'b1;
      pomo_ringing_r     <= 1'b0;
      work_min_r         <= PHASE_M_W'(1);
      break_min_r        <= PHASE_M_W'(1);
      phase_start_r      <= '0;
      phase_len_r        <= '0;
      mode_press_r       <= '0;
      pomo_press_r       <= '0;
      mode_held_r        <= 1'b0;
      pomo_held_r        <= 1'b0;
      hour_step_r        <= '0;
      min_step_r         <= '0;
      blink_tog_r        <= '0;
      blink_vis_r        <= 1'b1;
    end else if (mv0) begin
      alarm_hour_r       <= alarm_hour_nxt;
      alarm_minute_r     <= alarm_minute_nxt;
      last_seen_minute_r <= last_seen_minute_nxt;
      alarm_enabled_r    <= alarm_enabled_nxt;
      alarm_set_mode_r   <= alarm_set_mode_nxt;
      alarm_ringing_r    <= alarm_ringing_nxt;
      rang_r             <= rang_nxt;
      pomo_mode_r        <= pomo_mode_nxt;
      pomo_running_r     <= pomo_running_nxt;
      work_phase_r       <= work_phase_nxt;
      pomo_ringing_r     <= pomo_ringing_nxt;
      work_min_r         <= work_min_nxt;
      break_min_r        <= break_min_nxt;
      phase_start_r      <= phase_start_nxt;
      phase_len_r        <= phase_len_nxt;
      mode_press_r       <= mode_press_nxt;
      pomo_press_r       <= pomo_press_nxt;
      mode_held_r        <= mode_held_nxt;
      pomo_held_r        <= pomo_held_nxt;
      hour_step_r        <= hour_step_nxt;
      min_step_r         <= min_step_nxt;
      blink_tog_r        <= blink_tog_nxt;
      blink_vis_r        <= blink_vis_nxt;
    end
  end

  // display pipeline
  disp_t s1_r, s2_r, s3_r, s4_r;
  disp_t s2_nxt, s3_nxt, s4_nxt;
  logic [PHASE_L_W+24-1:0] prod_ms;
  logic [SECS_W+15-1:0]    prod_s;
  logic [SECS_W-1:0]       sec_rem;
  logic [VALUE_W-1:0]      value_nxt;

  assign prod_ms = (PHASE_L_W+24)'(s1_r.num) * (PHASE_L_W+24)'(REC_1000);
  assign prod_s  = (SECS_W+15)'(s2_r.num[SECS_W-1:0]) * (SECS_W+15)'(REC_60);
  assign sec_rem = s3_r.num[SECS_W-1:0] - SECS_W'(s3_r.hi) * SECS_W'(MINUTES_PER_HR);
  assign value_nxt = VALUE_W'(s4_r.hi) * VALUE_W'(100) + VALUE_W'(s4_r.lo);

  always_comb begin
    s2_nxt = s1_r;
    if (s1_r.use_div) s2_nxt.num = PHASE_L_W'(prod_ms[SH_1000 +: SECS_W]);
    s3_nxt = s2_r;
    if (s2_r.use_div) s3_nxt.hi = prod_s[SH_60 +: HI_W];
    s4_nxt = s3_r;
    if (s3_r.use_div) s4_nxt.lo = sec_rem[MINUTE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (free1) s1_r <= s1_nxt;
    if (free2) s2_r <= s2_nxt;
    if (free3) s3_r <= s3_nxt;
    if (free4) s4_r <= s4_nxt;
    if (free5) begin
      out_display_value <= value_nxt;
      out_colon_on      <= s4_r.colon;
      out_display_blank <= s4_r.blank;
      out_buzzer_on     <= s4_r.buzzer;
      out_chirp_code    <= s4_r.chirp;
    end
  end

  assign out_valid = vo_r;

  // checks
  a_modes_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(alarm_set_mode_r && pomo_mode_r))
    else $error("alarm set mode and pomodoro mode both active");

  a_run_ring_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(pomo_running_r && pomo_ringing_r))
    else $error("pomodoro running while ringing");

  a_alarm_time_range: assert property (@(posedge clk) disable iff (!rst_n)
    alarm_hour_r < HOURS_PER_DAY && alarm_minute_r < MINUTES_PER_HR)
    else $error("alarm time out of range");

  a_blank_clears: assert property (@(posedge clk) disable iff (!rst_n)
    vo_r && out_display_blank |-> out_display_value == '0 && !out_colon_on)
    else $error("blank word shows digits");

  a_chirp_code: assert property (@(posedge clk) disable iff (!rst_n)
    vo_r |-> out_chirp_code <= CHIRP_3X150)
    else $error("chirp code out of range");

  a_stage_advance: assert property (@(posedge clk) disable iff (!rst_n)
    v4_r && !vo_r |=> vo_r)
    else $error("last stage failed to load output register");

endmodule
`default_nettype wire
